// File: rtl/integer_to_decimal_text_defines.svh
// Assertion macros used by the output checker of the decimal text encoder.
`ifndef INTEGER_TO_DECIMAL_TEXT_DEFINES_SVH
`define INTEGER_TO_DECIMAL_TEXT_DEFINES_SVH

// Same-cycle implication, sampled on clk and disabled during reset.
`define ITDT_ASSERT_NOW(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("integer_to_decimal_text check failed");

// Next-cycle implication, sampled on clk and disabled during reset.
`define ITDT_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("integer_to_decimal_text check failed");

`endif

// File: rtl/itdt_pkg.sv
// Types, character codes and the conversion step shared by the decimal text encoder.
package itdt_pkg;

	localparam int BIN_W           = 32;
	localparam int BCD_DIGITS      = 10;
	localparam int BCD_W           = 4 * BCD_DIGITS;
	localparam int STEPS_PER_STAGE = 4;
	localparam int DD_STAGES       = BIN_W / STEPS_PER_STAGE;
	localparam int TEXT_LEN        = 11;
	localparam int CNT_W           = 4;

	localparam logic [7:0] CH_PLUS  = 8'h2B;
	localparam logic [7:0] CH_MINUS = 8'h2D;
	localparam logic [7:0] CH_COMMA = 8'h2C;
	localparam logic [7:0] CH_NL    = 8'h0A;
	localparam logic [7:0] CH_ZERO  = 8'h30;

	typedef enum logic [1:0] {
		FMT_S8  = 2'd0,
		FMT_S16 = 2'd1,
		FMT_U8  = 2'd2,
		FMT_U32 = 2'd3
	} fmt_t;

	typedef struct packed {
		logic [BCD_W-1:0] bcd;
		logic [BIN_W-1:0] bin;
		fmt_t             fmt;
		logic             neg;
		logic             use_comma;
	} dd_item_t;

	// One shift-and-add-three step over the combined decimal and binary word.
	function automatic logic [BCD_W+BIN_W-1:0] dd_step(input logic [BCD_W+BIN_W-1:0] w);
		logic [BCD_W+BIN_W-1:0] r;
		r = w;
		for (int i = 0; i < BCD_DIGITS; i++) begin
			if (r[BIN_W+4*i +: 4] >= 4'd5) begin
				r[BIN_W+4*i +: 4] = r[BIN_W+4*i +: 4] + 4'd3;
			end
		end
		return {r[BCD_W+BIN_W-2:0], 1'b0};
	endfunction

endpackage

// File: rtl/integer_to_decimal_text.sv
// An item goes through the input register, the conversion stages and the character register.
// Throughput: one character per cycle with m_tready high; items are 4, 5, 7 or 11 characters.
// That figure is set by the output character register, which sends one character per cycle.
// The conversion pipeline accepts a new item every cycle while downstream has room.
// Reset clears every valid bit and the character count; data registers are not reset.
module integer_to_decimal_text (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [31:0] s_tdata,  // value[31:0]
	input  logic [2:0]  s_tuser,  // cmd[1:0], use_comma[2]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [7:0]  m_tdata,  // character[7:0]
	output logic        m_tlast
);
	import itdt_pkg::*;

	logic         valid_s1;
	dd_item_t     item_s1;
	dd_item_t     in_item;
	logic [8:0]   mag8;
	logic [16:0]  mag16;
	logic         ready_s1;

	logic         pv [DD_STAGES+1];
	logic         pr [DD_STAGES+1];
	dd_item_t     pi [DD_STAGES+1];

	always_comb begin
		mag8  = s_tdata[7]  ? 9'(9'h100 - {1'b0, s_tdata[7:0]}) : {1'b0, s_tdata[7:0]};
		mag16 = s_tdata[15] ? 17'(17'h10000 - {1'b0, s_tdata[15:0]})
			: {1'b0, s_tdata[15:0]};
		in_item           = '0;
		in_item.fmt       = fmt_t'(s_tuser[1:0]);
		in_item.use_comma = s_tuser[2];
		unique case (fmt_t'(s_tuser[1:0]))
			FMT_S8: begin
				in_item.neg = s_tdata[7];
				in_item.bin = BIN_W'(mag8);
			end
			FMT_S16: begin
				in_item.neg = s_tdata[15];
				in_item.bin = BIN_W'(mag16);
			end
			FMT_U8: begin
				in_item.bin = BIN_W'(s_tdata[7:0]);
			end
			default: begin
				in_item.bin = s_tdata;
			end
		endcase
	end

	assign ready_s1 = !valid_s1 || pr[0];
	assign s_tready = ready_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (ready_s1) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (ready_s1 && s_tvalid) begin
			item_s1 <= in_item;
		end
	end

	assign pv[0] = valid_s1;
	assign pi[0] = item_s1;

	for (genvar g = 0; g < DD_STAGES; g++) begin : g_dd
		itdt_dd_stage u_stage (
			.clk       (clk),
			.arst_n    (arst_n),
			.in_valid  (pv[g]),
			.in_ready  (pr[g]),
			.in_item   (pi[g]),
			.out_valid (pv[g+1]),
			.out_ready (pr[g+1]),
			.out_item  (pi[g+1])
		);
	end

	itdt_serializer u_ser (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (pv[DD_STAGES]),
		.in_ready  (pr[DD_STAGES]),
		.in_item   (pi[DD_STAGES]),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.out_char  (m_tdata),
		.out_last  (m_tlast)
	);

endmodule

// File: rtl/itdt_dd_stage.sv
// One pipeline stage of the binary to decimal conversion, STEPS_PER_STAGE shift-add steps deep.
module itdt_dd_stage (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  itdt_pkg::dd_item_t in_item,
	output logic               out_valid,
	input  logic               out_ready,
	output itdt_pkg::dd_item_t out_item
);
	import itdt_pkg::*;

	logic                   valid_q;
	dd_item_t               item_q;
	dd_item_t               next_item;
	logic [BCD_W+BIN_W-1:0] word;

	always_comb begin
		word = {in_item.bcd, in_item.bin};
		for (int s = 0; s < STEPS_PER_STAGE; s++) begin
			word = dd_step(word);
		end
		next_item           = in_item;
		next_item.bcd       = word[BCD_W+BIN_W-1:BIN_W];
		next_item.bin       = word[BIN_W-1:0];
	end

	assign in_ready  = !valid_q || out_ready;
	assign out_valid = valid_q;
	assign out_item  = item_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (in_ready) begin
			valid_q <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			item_q <= next_item;
		end
	end

endmodule

// File: rtl/itdt_serializer.sv
// Formats a converted value into its character run and sends it one character per transaction.
module itdt_serializer (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  itdt_pkg::dd_item_t in_item,
	output logic               out_valid,
	input  logic               out_ready,
	output logic [7:0]         out_char,
	output logic               out_last
);
	import itdt_pkg::*;

	logic [CNT_W-1:0] cnt_q;
	logic [7:0]       chars_q [TEXT_LEN];
	logic [7:0]       text    [TEXT_LEN];
	logic [CNT_W-1:0] text_len;
	logic [7:0]       sign_ch;
	logic [7:0]       sep_ch;
	logic             load;
	logic             take;

	always_comb begin
		sign_ch = in_item.neg ? CH_MINUS : CH_PLUS;
		sep_ch  = in_item.use_comma ? CH_COMMA : CH_NL;
		for (int k = 0; k < TEXT_LEN; k++) begin
			text[k] = 8'h00;
		end
		unique case (in_item.fmt)
			FMT_S8: begin
				text[0] = sign_ch;
				for (int k = 0; k < 3; k++) begin
					text[1+k] = CH_ZERO | {4'h0, in_item.bcd[4*(2-k) +: 4]};
				end
				text[4]  = sep_ch;
				text_len = CNT_W'(5);
			end
			FMT_S16: begin
				text[0] = sign_ch;
				for (int k = 0; k < 5; k++) begin
					text[1+k] = CH_ZERO | {4'h0, in_item.bcd[4*(4-k) +: 4]};
				end
				text[6]  = sep_ch;
				text_len = CNT_W'(7);
			end
			FMT_U8: begin
				for (int k = 0; k < 3; k++) begin
					text[k] = CH_ZERO | {4'h0, in_item.bcd[4*(2-k) +: 4]};
				end
				text[3]  = sep_ch;
				text_len = CNT_W'(4);
			end
			default: begin
				for (int k = 0; k < BCD_DIGITS; k++) begin
					text[k] = CH_ZERO | {4'h0, in_item.bcd[4*(BCD_DIGITS-1-k) +: 4]};
				end
				text[BCD_DIGITS] = sep_ch;
				text_len         = CNT_W'(TEXT_LEN);
			end
		endcase
	end

	assign out_valid = (cnt_q != '0);
	assign out_char  = chars_q[0];
	assign out_last  = (cnt_q == CNT_W'(1));
	assign take      = out_valid && out_ready;
	assign in_ready  = !out_valid || (take && out_last);
	assign load      = in_ready && in_valid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (load) begin
			cnt_q <= text_len;
		end else if (take) begin
			cnt_q <= cnt_q - CNT_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			chars_q <= text;
		end else if (take) begin
			for (int k = 0; k < TEXT_LEN - 1; k++) begin
				chars_q[k] <= chars_q[k+1];
			end
		end
	end

endmodule

// File: rtl/itdt_checker.sv
// Port-level checks of the decimal text encoder output stream, bound to the top level.
`include "integer_to_decimal_text_defines.svh"

module itdt_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [7:0]  m_tdata,
	input logic        m_tlast
);
	import itdt_pkg::*;

	logic is_digit;
	logic is_sign;
	logic is_sep;

	assign is_digit = (m_tdata >= CH_ZERO) && (m_tdata <= (CH_ZERO + 8'd9));
	assign is_sign  = (m_tdata == CH_PLUS) || (m_tdata == CH_MINUS);
	assign is_sep   = (m_tdata == CH_COMMA) || (m_tdata == CH_NL);

	`ITDT_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tlast))
	`ITDT_ASSERT_NOW(a_last_is_sep, m_tvalid && m_tlast, is_sep)
	`ITDT_ASSERT_NOW(a_body_char, m_tvalid && !m_tlast, is_digit || is_sign)
	`ITDT_ASSERT_NEXT(a_run_gapless, m_tvalid && m_tready && !m_tlast, m_tvalid && (m_tlast || !is_sep))

endmodule

bind integer_to_decimal_text itdt_checker u_itdt_checker (.*);

// File: sim/integer_to_decimal_text_tb.sv
// Self-checking testbench for the decimal text encoder: directed table, then random items.
module integer_to_decimal_text_tb;
	import itdt_pkg::*;

	localparam int RANDOM_ITEMS = 420;
	localparam int CALM_FROM    = 360;
	localparam int STALL_LIMIT  = 2000;
	localparam int DRAIN_CYCLES = 30;
	localparam int PRINT_CAP    = 40;

	typedef struct packed {
		logic [7:0] character;
		logic       last;
	} due_char_t;

	typedef struct {
		fmt_t        fmt;
		logic [31:0] value;
		logic        use_comma;
		string       text;
	} text_row_t;

	// An empty text means the row is checked against the predictor.
	localparam int DIR_ROWS = 23;
	text_row_t dir_rows [DIR_ROWS] = '{
		'{FMT_S8,  32'h0000_0000, 1'b1, "+000,"},
		'{FMT_S8,  32'h0000_007F, 1'b0, "+127\n"},
		'{FMT_S8,  32'h0000_0080, 1'b1, "-128,"},
		'{FMT_S8,  32'h0000_00FF, 1'b0, "-001\n"},
		'{FMT_S8,  32'hFFFF_FF80, 1'b1, "-128,"},
		'{FMT_S8,  32'h0000_0005, 1'b0, ""},
		'{FMT_S16, 32'h0000_0000, 1'b0, "+00000\n"},
		'{FMT_S16, 32'h0000_7FFF, 1'b1, "+32767,"},
		'{FMT_S16, 32'h0000_8000, 1'b0, "-32768\n"},
		'{FMT_S16, 32'h0000_FFFF, 1'b1, "-00001,"},
		'{FMT_S16, 32'hABCD_8000, 1'b1, "-32768,"},
		'{FMT_S16, 32'h0000_3039, 1'b0, ""},
		'{FMT_U8,  32'h0000_0000, 1'b0, "000\n"},
		'{FMT_U8,  32'h0000_00FF, 1'b1, "255,"},
		'{FMT_U8,  32'hFFFF_FF00, 1'b1, "000,"},
		'{FMT_U8,  32'h0000_0099, 1'b0, ""},
		'{FMT_U32, 32'h0000_0000, 1'b0, "0000000000\n"},
		'{FMT_U32, 32'hFFFF_FFFF, 1'b1, "4294967295,"},
		'{FMT_U32, 32'h8000_0000, 1'b0, "2147483648\n"},
		'{FMT_U32, 32'h0000_0001, 1'b1, "0000000001,"},
		'{FMT_U32, 32'h075B_CD15, 1'b0, ""},
		'{FMT_U32, 32'h3B9A_CA00, 1'b1, ""},
		'{FMT_U32, 32'h3B9A_C9FF, 1'b0, ""}
	};

	logic        clk      = 1'b0;
	logic        arst_n   = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [31:0] s_tdata  = '0;
	logic [2:0]  s_tuser  = '0;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [7:0]  m_tdata;
	logic        m_tlast;

	due_char_t   text_due [$];
	due_char_t   want;
	bit          calm        = 1'b0;
	int          err_count   = 0;
	int          idle_cycles = 0;
	int          chars_seen  = 0;
	int          fmt_seen [4];
	fmt_t        r_fmt;
	logic [31:0] r_value;
	logic        r_comma;

	integer_to_decimal_text u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	function automatic void push_due(logic [7:0] ch, logic is_last);
		due_char_t c;
		c.character = ch;
		c.last      = is_last;
		text_due.push_back(c);
	endfunction

	function automatic void render_decimal(fmt_t f, logic [31:0] v, logic comma);
		logic [31:0] mag;
		logic [31:0] div;
		logic [31:0] d;
		logic        neg;
		logic        has_sign;
		int          ndig;
		neg      = 1'b0;
		has_sign = 1'b1;
		case (f)
			FMT_S8: begin
				neg  = v[7];
				mag  = neg ? 32'd256 - {24'd0, v[7:0]} : {24'd0, v[7:0]};
				ndig = 3;
			end
			FMT_S16: begin
				neg  = v[15];
				mag  = neg ? 32'd65536 - {16'd0, v[15:0]} : {16'd0, v[15:0]};
				ndig = 5;
			end
			FMT_U8: begin
				has_sign = 1'b0;
				mag      = {24'd0, v[7:0]};
				ndig     = 3;
			end
			default: begin
				has_sign = 1'b0;
				mag      = v;
				ndig     = 10;
			end
		endcase
		if (has_sign) begin
			push_due(neg ? CH_MINUS : CH_PLUS, 1'b0);
		end
		div = 32'd1;
		for (int i = 1; i < ndig; i++) begin
			div = div * 32'd10;
		end
		for (int i = 0; i < ndig; i++) begin
			d   = mag / div;
			push_due(CH_ZERO + 8'(d % 32'd10), 1'b0);
			mag = mag - d * div;
			div = (div > 32'd1) ? div / 32'd10 : 32'd1;
		end
		push_due(comma ? CH_COMMA : CH_NL, 1'b1);
	endfunction

	task automatic report_mismatch(string what, logic [7:0] got, logic [7:0] exp_val);
		err_count++;
		if (err_count <= PRINT_CAP) begin
			$display("MISMATCH at %0t: %s got 0x%02h expected 0x%02h", $realtime, what, got,
				exp_val);
		end
	endtask

	task automatic offer_number(fmt_t f, logic [31:0] v, logic comma, string text);
		if (!calm && $urandom_range(0, 3) == 0) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 5)) @(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= v;
		s_tuser  <= {comma, f};
		do @(posedge clk); while (!s_tready);
		fmt_seen[f]++;
		if (text.len() == 0) begin
			render_decimal(f, v, comma);
		end else begin
			for (int i = 0; i < text.len(); i++) begin
				push_due(text[i], i == text.len() - 1);
			end
		end
		@(negedge clk);
	endtask

	initial begin
		forever begin
			@(negedge clk);
			if (!calm && $urandom_range(0, 3) == 0) begin
				m_tready <= 1'b0;
				repeat ($urandom_range(1, 5) - 1) @(negedge clk);
			end else begin
				m_tready <= 1'b1;
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready) begin
			if (text_due.size() == 0) begin
				report_mismatch("unexpected character", m_tdata, 8'h00);
			end else begin
				want = text_due.pop_front();
				if (m_tdata !== want.character) begin
					report_mismatch("character", m_tdata, want.character);
				end
				if (m_tlast !== want.last) begin
					report_mismatch("last flag", {7'd0, m_tlast}, {7'd0, want.last});
				end
				chars_seen++;
			end
		end
	end

	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
			idle_cycles <= 0;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
		if (idle_cycles == STALL_LIMIT) begin
			$display("integer_to_decimal_text verification failed");
			$finish;
		end
	end

	initial begin
		repeat (6) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);
		foreach (dir_rows[i]) begin
			offer_number(dir_rows[i].fmt, dir_rows[i].value, dir_rows[i].use_comma,
				dir_rows[i].text);
		end
		for (int n = 0; n < RANDOM_ITEMS; n++) begin
			calm    = (n >= CALM_FROM);
			r_fmt   = fmt_t'($urandom_range(0, 3));
			r_comma = 1'($urandom_range(0, 1));
			case ($urandom_range(0, 5))
				0: r_value = $urandom_range(0, 20);
				1: r_value = 32'd1 << $urandom_range(0, 31);
				2: r_value = ~(32'd1 << $urandom_range(0, 31));
				3: r_value = {16'($urandom_range(0, 65535)), 16'h7FFF} + $urandom_range(0, 2);
				4: r_value = {8'($urandom_range(0, 255)), 24'hFF_FF7F} + $urandom_range(0, 2);
				default: r_value = $urandom;
			endcase
			offer_number(r_fmt, r_value, r_comma, "");
		end
		s_tvalid <= 1'b0;
		while (text_due.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		$display("Converted %0d numbers (s8 %0d, s16 %0d, u8 %0d, u32 %0d) into %0d characters.",
			DIR_ROWS + RANDOM_ITEMS, fmt_seen[FMT_S8], fmt_seen[FMT_S16], fmt_seen[FMT_U8],
			fmt_seen[FMT_U32], chars_seen);
		$display("Mismatches counted: %0d.", err_count);
		if (err_count == 0) begin
			$display("integer_to_decimal_text verification clean");
		end else begin
			$display("integer_to_decimal_text verification failed");
		end
		$finish;
	end

endmodule

// File: sim.f
+incdir+rtl
rtl/itdt_pkg.sv
rtl/itdt_dd_stage.sv
rtl/itdt_serializer.sv
rtl/integer_to_decimal_text.sv
rtl/itdt_checker.sv
sim/integer_to_decimal_text_tb.sv
